[hw/rtl/spr_pkg.sv]
package spr_pkg;

  localparam int unsigned MUL_BITS = 16;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned DIV_W    = 18;
  localparam int unsigned DVS_W    = 8;

  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_FF_GAIN     = 3'd2;
  localparam logic [2:0] REG_SPEED_STEP  = 3'd3;
  localparam logic [2:0] REG_PSTEP_UP    = 3'd4;
  localparam logic [2:0] REG_PSTEP_DOWN  = 3'd5;
  localparam logic [2:0] REG_POWER_LIMIT = 3'd6;
  localparam logic [2:0] REG_STEER_OFS   = 3'd7;

  localparam logic signed [31:0] ESUM_CLAMP     = 32'sd655360000;
  localparam logic signed [17:0] SERVO_CENTER   = 18'sd23040;
  localparam logic [15:0]        SERVO_MUL      = 16'd3795;
  localparam logic signed [31:0] SERVO_BASE_NUM = 32'sd43776000;
  localparam logic [15:0]        DUTY_MUL       = 16'd1023;
  localparam logic [7:0]         DUTY_DVS       = 8'd255;
  localparam logic [7:0]         SERVO_DVS      = 8'd125;
  localparam logic [9:0]         PWM_MAX        = 10'd1023;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_BITS-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
  } div_req_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RAMP   = 11'b00000000010,
    S_MUL_FF = 11'b00000000100,
    S_MUL_P  = 11'b00000001000,
    S_MUL_I  = 11'b00000010000,
    S_PID    = 11'b00000100000,
    S_MUL_D  = 11'b00001000000,
    S_DIV_D  = 11'b00010000000,
    S_MUL_S  = 11'b00100000000,
    S_DIV_S  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

endpackage

[hw/rtl/spr_in_if.sv]
interface spr_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] target_speed;
  logic signed [23:0] measured_speed;
  logic signed [15:0] steer_request;

  modport source(output valid, output target_speed, output measured_speed,
                 output steer_request, input ready);
  modport sink(input valid, input target_speed, input measured_speed,
               input steer_request, output ready);
endinterface

[hw/rtl/spr_out_if.sv]
interface spr_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         motor_duty;
  logic               reverse_dir;
  logic [9:0]         servo_ticks;
  logic signed [23:0] power_applied;

  modport source(output valid, output motor_duty, output reverse_dir,
                 output servo_ticks, output power_applied, input ready);
  modport sink(input valid, input motor_duty, input reverse_dir,
               input servo_ticks, input power_applied, output ready);
endinterface

[hw/rtl/spr_mul.sv]
module spr_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spr_pkg::mul_req_t         req_i,
  output logic                      done_o,
  output logic signed [spr_pkg::PROD_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(spr_pkg::MUL_BITS + 1);

  logic [spr_pkg::PROD_W-1:0]   a_q;
  logic [spr_pkg::MUL_BITS-1:0] b_q;
  logic [spr_pkg::PROD_W-1:0]   acc_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(spr_pkg::MUL_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle, lsb first
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= {{(spr_pkg::PROD_W - spr_pkg::MUL_A_W){req_i.a[spr_pkg::MUL_A_W-1]}},
                req_i.a};
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
      a_q   <= {a_q[spr_pkg::PROD_W-2:0], 1'b0};
      b_q   <= {1'b0, b_q[spr_pkg::MUL_BITS-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("multiplier restarted while busy");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("busy with empty count");

endmodule

[hw/rtl/spr_div.sv]
module spr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spr_pkg::div_req_t            req_i,
  output logic                         done_o,
  output logic [spr_pkg::DIV_W-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(spr_pkg::DIV_W + 1);

  logic [spr_pkg::DIV_W-1:0] dq_q;
  logic [spr_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic [spr_pkg::DVS_W:0]   trial;
  logic                      qbit;

  assign trial = {rem_q, dq_q[spr_pkg::DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(spr_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dvd;
      dvs_q <= req_i.dvs;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? spr_pkg::DVS_W'(trial - {1'b0, dvs_q})
                    : trial[spr_pkg::DVS_W-1:0];
      dq_q  <= {dq_q[spr_pkg::DIV_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start) |-> rem_q < dvs_q) else $error("remainder too large");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");

endmodule

[hw/rtl/speed_pi_controller_with_ramps_unit.sv]
// channel  | dir | modport | payload
// in_i     | in  | sink    | target_speed, measured_speed, steer_request
// out_o    | out | source  | motor_duty, reverse_dir, servo_ticks, power_applied
// cfg      | in  | write   | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// each transaction runs the ramp state, three bit-serial multiplies (feed-forward,
// proportional, integral), the pid state, a bit-serial multiply and divide for the
// duty, another pair for the servo, then the output state and back to idle
// one transaction in flight; in_i.ready is high only in the idle state
// the result register lets the next transaction start while out_o stalls
// reset clears ramp, integral and applied power and loads the default gains, steps, power limit and steer offset
module speed_pi_controller_with_ramps_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  spr_in_if.sink      in_i,
  spr_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [22:0] cfg_wdata_i
);

  spr_pkg::state_e state_q;

  logic [15:0]        prop_gain_q, integ_gain_q, ff_gain_q, speed_step_q;
  logic [15:0]        pstep_up_q, pstep_dn_q;
  logic [22:0]        power_limit_q;
  logic signed [13:0] steer_ofs_q;

  logic signed [23:0] tgt_q, meas_q, rt_q, lp_q;
  logic signed [15:0] steer_q;
  logic signed [31:0] es_q;
  logic signed [24:0] err_q;
  logic signed [16:0] ang_q;
  logic signed [35:0] pid_q;
  logic [17:0]        div_arg_q;
  logic               servo_neg_q;
  logic [9:0]         duty_q;
  logic               mul_go_q, div_go_q;

  logic               out_valid_q;
  logic [9:0]         out_duty_q, out_ticks_q;
  logic               out_rev_q;
  logic signed [23:0] out_pow_q;

  spr_pkg::mul_req_t  mul_req;
  spr_pkg::div_req_t  div_req;
  logic               mul_done, div_done;
  logic signed [47:0] mul_prod;
  logic [17:0]        div_quot;

  logic               in_acc;
  logic               out_load;
  logic signed [24:0] rt_up, tgt25, rt25;
  logic signed [25:0] rt_dn, tgt26;
  logic signed [23:0] rt_new;
  logic signed [35:0] lim36, pid_cl;
  logic signed [24:0] lp25, lp_up, lp_dn, pid25;
  logic signed [23:0] newp;
  logic signed [32:0] es_sum;
  logic signed [31:0] es_new;
  logic [23:0]        mag;
  logic signed [17:0] servo_d;
  logic signed [31:0] servo_num;
  logic [9:0]         quot_sat;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == spr_pkg::S_IDLE);
  assign out_load   = (state_q == spr_pkg::S_OUT) && (!out_valid_q || out_o.ready);

  spr_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .done_o(mul_done), .prod_o(mul_prod));
  spr_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(div_quot));

  always_comb begin
    tgt25 = {tgt_q[23], tgt_q};
    rt25  = {rt_q[23], rt_q};
    tgt26 = {tgt25[24], tgt25};
    rt_up = rt25 + $signed({9'b0, speed_step_q});
    rt_dn = {rt25[24], rt25} - $signed({9'b0, speed_step_q, 1'b0});
    if (tgt_q > rt_q) begin
      rt_new = (tgt25 < rt_up) ? tgt_q : rt_up[23:0];
    end else if (tgt_q < rt_q) begin
      rt_new = (tgt26 > rt_dn) ? tgt_q : rt_dn[23:0];
    end else begin
      rt_new = rt_q;
    end

    lim36  = $signed({13'b0, power_limit_q});
    if (pid_q > lim36) begin
      pid_cl = lim36;
    end else if (pid_q < -lim36) begin
      pid_cl = -lim36;
    end else begin
      pid_cl = pid_q;
    end
    pid25 = pid_cl[24:0];
    lp25  = {lp_q[23], lp_q};
    lp_up = lp25 + $signed({9'b0, pstep_up_q});
    lp_dn = lp25 - $signed({9'b0, pstep_dn_q});
    if (pid25 > lp25) begin
      newp = (pid25 < lp_up) ? pid25[23:0] : lp_up[23:0];
    end else if (pid25 < lp25) begin
      newp = (pid25 > lp_dn) ? pid25[23:0] : lp_dn[23:0];
    end else begin
      newp = lp_q;
    end

    es_sum = {es_q[31], es_q} + {{8{err_q[24]}}, err_q};
    if (rt_q == '0) begin
      es_new = '0;
    end else if (es_sum > $signed({spr_pkg::ESUM_CLAMP[31], spr_pkg::ESUM_CLAMP})) begin
      es_new = spr_pkg::ESUM_CLAMP;
    end else if (es_sum < -$signed({spr_pkg::ESUM_CLAMP[31], spr_pkg::ESUM_CLAMP})) begin
      es_new = -spr_pkg::ESUM_CLAMP;
    end else begin
      es_new = es_sum[31:0];
    end

    mag       = lp_q[23] ? (~lp_q + 24'd1) : lp_q;
    servo_d   = spr_pkg::SERVO_CENTER - {ang_q[16], ang_q};
    servo_num = mul_prod[31:0] + spr_pkg::SERVO_BASE_NUM;
    quot_sat  = (div_quot > {8'b0, spr_pkg::PWM_MAX}) ? spr_pkg::PWM_MAX : div_quot[9:0];
  end

  always_comb begin
    mul_req.start = mul_go_q;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (state_q)
      spr_pkg::S_MUL_FF: begin
        mul_req.a = {{8{rt_q[23]}}, rt_q};
        mul_req.b = ff_gain_q;
      end
      spr_pkg::S_MUL_P: begin
        mul_req.a = {{7{err_q[24]}}, err_q};
        mul_req.b = prop_gain_q;
      end
      spr_pkg::S_MUL_I: begin
        mul_req.a = es_q;
        mul_req.b = integ_gain_q;
      end
      spr_pkg::S_MUL_D: begin
        mul_req.a = {8'b0, mag};
        mul_req.b = spr_pkg::DUTY_MUL;
      end
      spr_pkg::S_MUL_S: begin
        mul_req.a = {{14{servo_d[17]}}, servo_d};
        mul_req.b = spr_pkg::SERVO_MUL;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
    div_req.start = div_go_q;
    div_req.dvd   = div_arg_q;
    div_req.dvs   = (state_q == spr_pkg::S_DIV_S) ? spr_pkg::SERVO_DVS : spr_pkg::DUTY_DVS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= 16'd1024;
      integ_gain_q  <= 16'd655;
      ff_gain_q     <= 16'd2560;
      speed_step_q  <= 16'd328;
      pstep_up_q    <= 16'd6554;
      pstep_dn_q    <= 16'd5243;
      power_limit_q <= 23'd6553600;
      steer_ofs_q   <= -14'sd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spr_pkg::REG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i[15:0];
        spr_pkg::REG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i[15:0];
        spr_pkg::REG_FF_GAIN:     ff_gain_q     <= cfg_wdata_i[15:0];
        spr_pkg::REG_SPEED_STEP:  speed_step_q  <= cfg_wdata_i[15:0];
        spr_pkg::REG_PSTEP_UP:    pstep_up_q    <= cfg_wdata_i[15:0];
        spr_pkg::REG_PSTEP_DOWN:  pstep_dn_q    <= cfg_wdata_i[15:0];
        spr_pkg::REG_POWER_LIMIT: power_limit_q <= cfg_wdata_i;
        spr_pkg::REG_STEER_OFS:   steer_ofs_q   <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spr_pkg::S_IDLE;
      rt_q        <= '0;
      es_q        <= '0;
      lp_q        <= '0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        spr_pkg::S_IDLE: begin
          if (in_acc) begin
            state_q <= spr_pkg::S_RAMP;
          end
        end
        spr_pkg::S_RAMP: begin
          rt_q     <= rt_new;
          state_q  <= spr_pkg::S_MUL_FF;
          mul_go_q <= 1'b1;
        end
        spr_pkg::S_MUL_FF: begin
          if (mul_done) begin
            state_q  <= spr_pkg::S_MUL_P;
            mul_go_q <= 1'b1;
          end
        end
        spr_pkg::S_MUL_P: begin
          if (mul_done) begin
            state_q  <= spr_pkg::S_MUL_I;
            mul_go_q <= 1'b1;
          end
        end
        spr_pkg::S_MUL_I: begin
          if (mul_done) begin
            state_q <= spr_pkg::S_PID;
          end
        end
        spr_pkg::S_PID: begin
          lp_q     <= newp;
          es_q     <= es_new;
          state_q  <= spr_pkg::S_MUL_D;
          mul_go_q <= 1'b1;
        end
        spr_pkg::S_MUL_D: begin
          if (mul_done) begin
            state_q  <= spr_pkg::S_DIV_D;
            div_go_q <= 1'b1;
          end
        end
        spr_pkg::S_DIV_D: begin
          if (div_done) begin
            state_q  <= spr_pkg::S_MUL_S;
            mul_go_q <= 1'b1;
          end
        end
        spr_pkg::S_MUL_S: begin
          if (mul_done) begin
            state_q  <= spr_pkg::S_DIV_S;
            div_go_q <= 1'b1;
          end
        end
        spr_pkg::S_DIV_S: begin
          if (div_done) begin
            state_q <= spr_pkg::S_OUT;
          end
        end
        spr_pkg::S_OUT: begin
          if (out_load) begin
            state_q <= spr_pkg::S_IDLE;
          end
        end
        default: state_q <= spr_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q   <= in_i.target_speed;
      meas_q  <= in_i.measured_speed;
      steer_q <= in_i.steer_request;
    end
    if (state_q == spr_pkg::S_RAMP) begin
      ang_q <= {steer_q[15], steer_q} + {{3{steer_ofs_q[13]}}, steer_ofs_q};
    end
    if (state_q == spr_pkg::S_MUL_FF) begin
      err_q <= {rt_q[23], rt_q} - {meas_q[23], meas_q};
    end
    if (mul_done) begin
      case (state_q)
        spr_pkg::S_MUL_FF: pid_q <= 36'(mul_prod >>> 8);
        spr_pkg::S_MUL_P:  pid_q <= pid_q + 36'(mul_prod >>> 8);
        spr_pkg::S_MUL_I:  pid_q <= pid_q + 36'(mul_prod >>> 16);
        spr_pkg::S_MUL_D:  div_arg_q <= mul_prod[33:16];
        spr_pkg::S_MUL_S: begin
          div_arg_q   <= servo_num[28:11];
          servo_neg_q <= servo_num[31];
        end
        default: ;
      endcase
    end
    if (div_done && state_q == spr_pkg::S_DIV_D) begin
      duty_q <= quot_sat;
    end
    // quotient stays in the divider until its next start
    if (out_load) begin
      out_ticks_q <= servo_neg_q ? 10'd0 : quot_sat;
      out_duty_q  <= duty_q;
      out_pow_q   <= lp_q;
      out_rev_q   <= (lp_q <= -24'sd65536);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.motor_duty    = out_duty_q;
  assign out_o.reverse_dir   = out_rev_q;
  assign out_o.servo_ticks   = out_ticks_q;
  assign out_o.power_applied = out_pow_q;

  a_accept_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == spr_pkg::S_RAMP) else $error("accept did not start ramp");
  a_esum_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (es_q <= spr_pkg::ESUM_CLAMP) && (es_q >= -spr_pkg::ESUM_CLAMP))
    else $error("integral out of clamp");
  a_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == spr_pkg::S_MUL_FF || state_q == spr_pkg::S_MUL_P ||
                  state_q == spr_pkg::S_MUL_I || state_q == spr_pkg::S_MUL_D ||
                  state_q == spr_pkg::S_MUL_S))
    else $error("multiply finished outside a multiply step");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == spr_pkg::S_DIV_D || state_q == spr_pkg::S_DIV_S))
    else $error("divide finished outside a divide step");

endmodule
